>>> rtl/command_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// command_frame_deframer_macros
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define CFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// checked at every edge, reset included
`define CFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define CFD_ASSERT(label, clk, rst_n, prop)
`define CFD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants of the command frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 24;

    localparam logic [BYTE_W-1:0] ID_LIMIT_RST = 8'd16;

    typedef enum logic [1:0] {
        EV_HEADER  = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_ERROR   = 2'd2
    } t_event;

    typedef enum logic [4:0] {
        PH_ID   = 5'b00001,
        PH_LEN1 = 5'b00010,
        PH_LEN2 = 5'b00100,
        PH_LEN3 = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

endpackage

>>> rtl/command_frame_deframer.sv
// ----------------------------------------------------------------------------
// command_frame_deframer
// Splits a received byte stream into id / length / payload command frames.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte), one
//   per transaction. Each byte yields exactly one result transaction on the
//   res channel: header, payload or error event, the frame's command id, the
//   payload byte, an end-of-frame flag and the frame length once known.
//   A frame is an id byte, a 24-bit little-endian length, then the payload.
//   Id bytes at or above id_limit are reported as errors and dropped.
//   The user writes id_limit through i_cfg_wr_en / i_cfg_wr_data only while
//   idle; the block itself does not enforce this.
// Timing:
//   One byte per cycle sustained while i_res_ready stays high. A byte is
//   registered on accept and then decoded against the frame state into the
//   result register that drives o_res_valid. The frame state update is a
//   single pass of byte-wide logic and a 24-bit decrement; nothing iterates.
// Reset and stall:
//   Reset empties both stages, returns to waiting for an id and sets
//   id_limit to 16. When the receiver holds i_res_ready low the result
//   register and then the input register fill, after which o_rx_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "command_frame_deframer_macros.svh"

module command_frame_deframer
    import cfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data,

    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,

    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [1:0]        o_event_res,
    output logic [BYTE_W-1:0] o_cmd_id,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_frame_end,
    output logic [LEN_W-1:0]  o_frame_length
);

    logic [BYTE_W-1:0] r_id_limit;

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // frame state
    t_phase            r_phase,        n_phase;
    logic [BYTE_W-1:0] r_current_id,   n_current_id;
    logic [LEN_W-1:0]  r_bytes_left,   n_bytes_left;
    logic [LEN_W-1:0]  r_total_length, n_total_length;

    // result stage
    logic              r_out_valid;
    t_event            r_event,        n_event;
    logic [BYTE_W-1:0] r_cmd_id,       n_cmd_id;
    logic [BYTE_W-1:0] r_payload,      n_payload;
    logic              r_frame_end,    n_frame_end;
    logic [LEN_W-1:0]  r_frame_length, n_frame_length;

    logic              w_advance;
    logic              w_process;
    logic [LEN_W-1:0]  w_left_dec;

    assign w_advance  = !r_out_valid || i_res_ready;
    assign w_process  = r_in_valid && w_advance;
    assign o_rx_ready = !r_in_valid || w_advance;
    assign w_left_dec = r_bytes_left - LEN_W'(1);

    always_comb begin
        n_phase        = r_phase;
        n_current_id   = r_current_id;
        n_bytes_left   = r_bytes_left;
        n_total_length = r_total_length;
        n_event        = EV_HEADER;
        n_cmd_id       = r_current_id;
        n_payload      = '0;
        n_frame_end    = 1'b0;
        n_frame_length = '0;

        unique case (r_phase)
            PH_LEN1: begin
                n_total_length = LEN_W'(r_in_byte);
                n_phase        = PH_LEN2;
            end
            PH_LEN2: begin
                n_total_length = r_total_length | {8'd0, r_in_byte, 8'd0};
                n_phase        = PH_LEN3;
            end
            PH_LEN3: begin
                n_total_length = r_total_length | {r_in_byte, 16'd0};
                n_bytes_left   = n_total_length;
                n_frame_length = n_total_length;
                if (n_total_length == '0) begin
                    n_frame_end = 1'b1;
                    n_phase     = PH_ID;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_event        = EV_PAYLOAD;
                n_payload      = r_in_byte;
                n_frame_length = r_total_length;
                n_bytes_left   = w_left_dec;
                if (w_left_dec == '0) begin
                    n_frame_end = 1'b1;
                    n_phase     = PH_ID;
                end
            end
            default: begin
                // waiting for an id; stray codes land here too
                n_cmd_id = r_in_byte;
                if (r_in_byte >= r_id_limit) begin
                    n_event = EV_ERROR;
                    n_phase = PH_ID;
                end else begin
                    n_current_id   = r_in_byte;
                    n_total_length = '0;
                    n_bytes_left   = '0;
                    n_phase        = PH_LEN1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_limit     <= ID_LIMIT_RST;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_ID;
            r_current_id   <= '0;
            r_bytes_left   <= '0;
            r_total_length <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_id_limit <= i_cfg_wr_data;
            end
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_process) begin
                r_phase        <= n_phase;
                r_current_id   <= n_current_id;
                r_bytes_left   <= n_bytes_left;
                r_total_length <= n_total_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_process) begin
            r_event        <= n_event;
            r_cmd_id       <= n_cmd_id;
            r_payload      <= n_payload;
            r_frame_end    <= n_frame_end;
            r_frame_length <= n_frame_length;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_cmd_id       = r_cmd_id;
    assign o_payload_byte = r_payload;
    assign o_frame_end    = r_frame_end;
    assign o_frame_length = r_frame_length;

    `CFD_ASSERT(a_payload_zero, i_clk, i_rst_n, (o_res_valid && o_event_res != EV_PAYLOAD) |-> (o_payload_byte == '0))
    `CFD_ASSERT(a_error_clean, i_clk, i_rst_n, (o_res_valid && o_event_res == EV_ERROR) |-> (!o_frame_end && o_frame_length == '0))
    `CFD_ASSERT(a_data_left, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_bytes_left != '0))
    `CFD_ASSERT(a_payload_len, i_clk, i_rst_n, (o_res_valid && o_event_res == EV_PAYLOAD) |-> (o_frame_length != '0))
    `CFD_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_res_valid))

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for command_frame_deframer. Bytes go in as well-formed
// id/length/payload frames mixed with out-of-range id bytes. Every accepted
// byte runs through a predictor of the frame decoder, and every result
// transaction is compared field by field against the oldest prediction.
// Runs under several id_limit values, with random gaps on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import cfd_pkg::*;
();

    typedef struct {
        t_event            ev;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_frame_result;

    // Frame decoder predictor plus the queue of results still owed by the DUT
    class frame_scoreboard;
        logic [BYTE_W-1:0] id_limit;
        t_phase            phase;
        logic [BYTE_W-1:0] cur_id;
        logic [LEN_W-1:0]  remaining;
        logic [LEN_W-1:0]  total_len;
        t_frame_result     pending_q[$];
        int                mismatches;

        function void reset_state();
            id_limit   = ID_LIMIT_RST;
            phase      = PH_ID;
            cur_id     = '0;
            remaining  = '0;
            total_len  = '0;
            mismatches = 0;
            pending_q.delete();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_frame_result r;
            r.ev   = EV_HEADER;
            r.id   = cur_id;
            r.data = '0;
            r.last = 1'b0;
            r.len  = '0;
            case (phase)
                PH_LEN1: begin
                    total_len = {16'd0, b};
                    phase     = PH_LEN2;
                end
                PH_LEN2: begin
                    total_len[15:8] = b;
                    phase           = PH_LEN3;
                end
                PH_LEN3: begin
                    total_len[23:16] = b;
                    remaining        = total_len;
                    r.len            = total_len;
                    if (total_len == '0) begin
                        r.last = 1'b1;
                        phase  = PH_ID;
                    end else begin
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r.ev      = EV_PAYLOAD;
                    r.data    = b;
                    r.len     = total_len;
                    remaining = remaining - 1'b1;
                    if (remaining == '0) begin
                        r.last = 1'b1;
                        phase  = PH_ID;
                    end
                end
                default: begin
                    r.id = b;
                    if (b >= id_limit) begin
                        r.ev  = EV_ERROR;
                        phase = PH_ID;
                    end else begin
                        cur_id    = b;
                        total_len = '0;
                        remaining = '0;
                        phase     = PH_LEN1;
                    end
                end
            endcase
            pending_q.push_back(r);
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result ev=%0d id=%0h data=%0h ",
                             $realtime, got.ev, got.id, got.data,
                             "end=%0b len=%0h", got.last, got.len);
                return;
            end
            want = pending_q.pop_front();
            if (got.ev !== want.ev || got.id !== want.id || got.data !== want.data ||
                got.last !== want.last || got.len !== want.len) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp ev=%0d id=%0h data=%0h end=%0b len=%0h, ",
                             $realtime, want.ev, want.id, want.data, want.last, want.len,
                             "got ev=%0d id=%0h data=%0h end=%0b len=%0h",
                             got.ev, got.id, got.data, got.last, got.len);
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [BYTE_W-1:0] cfg_wr_data  = '0;
    logic              rx_valid     = 1'b0;
    logic [BYTE_W-1:0] rx_byte      = '0;
    logic              res_ready    = 1'b0;

    logic              rx_ready;
    logic              res_valid;
    logic [1:0]        event_res;
    logic [BYTE_W-1:0] cmd_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_length;

    int tx_gap_pct  = 0;
    int rx_gap_pct  = 0;
    int hold_cycles = 0;

    frame_scoreboard sb;

    command_frame_deframer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_event_res    (event_res),
        .o_cmd_id       (cmd_id),
        .o_payload_byte (payload_byte),
        .o_frame_end    (frame_end),
        .o_frame_length (frame_length)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls, or a solid hold-off while hold_cycles runs down
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                res_ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_ready <= ($urandom_range(0, 99) >= rx_gap_pct);
            end
        end
    end

    // Transaction monitor on both channels
    always @(posedge clk) begin
        t_frame_result got;
        if (rst_n) begin
            if (rx_valid && rx_ready)
                sb.note_byte(rx_byte);
            if (res_valid && res_ready) begin
                got.ev   = t_event'(event_res);
                got.id   = cmd_id;
                got.data = payload_byte;
                got.last = frame_end;
                got.len  = frame_length;
                sb.check_result(got);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                              inout int sent);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
        sent += 4 + int'(len);
    endtask

    // Mostly complete frames (only rejected id bytes when id_limit is 0); the rest are id bytes the block must reject
    task automatic send_random_traffic(input int n);
        int sent;
        int pick;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < n) begin
            if (sb.id_limit == 0 || $urandom_range(0, 99) < 15) begin
                send_byte(8'($urandom_range(sb.id_limit, 255)));
                sent++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = '0;
                else if (pick < 90)
                    len = LEN_W'($urandom_range(1, 8));
                else if (pick < 97)
                    len = LEN_W'($urandom_range(9, 40));
                else
                    len = LEN_W'($urandom_range(256, 300));
                send_frame(8'($urandom_range(0, sb.id_limit - 1)), len, sent);
            end
        end
        rx_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_id_limit(input logic [BYTE_W-1:0] v);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.id_limit = v;
        @(negedge clk);
    endtask

    initial begin
        int n;
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset id_limit
        tx_gap_pct = 33;
        rx_gap_pct = 50;
        n = 0;
        send_frame(8'd0, 24'd0, n);          // empty frame ends on last length byte
        send_byte(8'd16);                    // first id past the limit
        send_byte(8'd255);
        send_frame(8'd15, 24'd2, n);
        rx_valid <= 1'b0;
        @(negedge clk);
        send_byte(8'd7);
        send_byte(8'd1);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'd3);
        send_byte(8'd2);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'h00);
        send_byte(8'hA5);
        rx_valid <= 1'b0;

        write_id_limit(8'd255);
        send_random_traffic(260);
        write_id_limit(8'd0);                // every id rejected
        send_random_traffic(30);
        write_id_limit(8'd1);
        send_random_traffic(130);

        tx_gap_pct = 50;
        rx_gap_pct = 33;
        write_id_limit(8'($urandom_range(2, 254)));
        hold_cycles = 400;                   // block backs up and drops rx ready
        send_random_traffic(220);
        write_id_limit(8'd16);
        send_random_traffic(80);

        tx_gap_pct = 0;
        rx_gap_pct = 0;
        write_id_limit(8'($urandom_range(1, 255)));
        send_random_traffic(120);

        wait_for_results();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
